@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files of the PROXY v2 header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pv2hp_pkg.sv @@
// Types, constants and helper functions for the PROXY v2 header parser.
package pv2hp_pkg;

    localparam int unsigned IdxW     = 17;
    localparam int unsigned AddrLenW = 16;
    localparam int unsigned IpW      = 32;
    localparam int unsigned PortW    = 16;
    localparam int unsigned SigLen   = 12;

    localparam logic [IdxW-1:0]     IDX_MAX    = {IdxW{1'b1}};
    localparam logic [IdxW-1:0]     FIXED_HDR  = IdxW'(16);
    localparam logic [AddrLenW-1:0] INET_BLOCK = AddrLenW'(12);

    localparam logic [IdxW-1:0] POS_VER_CMD = IdxW'(12);
    localparam logic [IdxW-1:0] POS_FAMILY  = IdxW'(13);
    localparam logic [IdxW-1:0] POS_LEN_HI  = IdxW'(14);
    localparam logic [IdxW-1:0] POS_LEN_LO  = IdxW'(15);
    localparam logic [IdxW-1:0] POS_SRC_LO  = IdxW'(16);
    localparam logic [IdxW-1:0] POS_SRC_HI  = IdxW'(19);
    localparam logic [IdxW-1:0] POS_PORT_HI = IdxW'(24);
    localparam logic [IdxW-1:0] POS_PORT_LO = IdxW'(25);

    localparam logic [3:0] VERSION_2   = 4'h2;
    localparam logic [3:0] CMD_PROXY   = 4'h1;
    localparam logic [7:0] FAM_TCP4    = 8'h11;
    localparam logic [7:0] FAM_UDP4    = 8'h12;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_SIG   = 3'd2,
        ST_VER   = 3'd3,
        ST_CMD   = 3'd4,
        ST_FAM   = 3'd5,
        ST_SMALL = 3'd6,
        ST_OVER  = 3'd7
    } status_t;

    typedef struct packed {
        logic step;
        logic last;
    } pv2hp_ctl_t;

    typedef struct packed {
        status_t           status;
        logic [IpW-1:0]    client_address;
        logic [PortW-1:0]  client_port;
        logic [IdxW-1:0]   header_length;
    } pv2hp_result_t;

    // Expected signature byte at positions 0..11.
    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        logic [7:0] b;
        begin
            unique case (pos)
                4'd0:    b = 8'h0D;
                4'd1:    b = 8'h0A;
                4'd2:    b = 8'h0D;
                4'd3:    b = 8'h0A;
                4'd4:    b = 8'h00;
                4'd5:    b = 8'h0D;
                4'd6:    b = 8'h0A;
                4'd7:    b = 8'h51;
                4'd8:    b = 8'h55;
                4'd9:    b = 8'h49;
                4'd10:   b = 8'h54;
                4'd11:   b = 8'h0A;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

@@ rtl/core/pv2hp_parser.sv @@
// Per-packet parse state: byte counter, first fault, captured fields and verdict.
module pv2hp_parser
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pv2hp_pkg::pv2hp_ctl_t    ctl,
    input  logic [7:0]               data_byte,
    output pv2hp_pkg::pv2hp_result_t result
);

    logic [pv2hp_pkg::IdxW-1:0]     byte_index_reg, byte_index_next;
    pv2hp_pkg::status_t             first_error_reg, first_error_next;
    logic [pv2hp_pkg::AddrLenW-1:0] addr_len_reg, addr_len_next;
    logic [pv2hp_pkg::IpW-1:0]      src_addr_reg, src_addr_next;
    logic [pv2hp_pkg::PortW-1:0]    src_port_reg, src_port_next;

    pv2hp_pkg::status_t             err;
    pv2hp_pkg::status_t             verdict;
    logic [pv2hp_pkg::IdxW-1:0]     pkt_len;
    logic [pv2hp_pkg::IdxW-1:0]     room;

    // Check or capture the byte at its position.
    always_comb
    begin
        err           = pv2hp_pkg::ST_OK;
        addr_len_next = addr_len_reg;
        src_addr_next = src_addr_reg;
        src_port_next = src_port_reg;
        priority if (byte_index_reg < pv2hp_pkg::IdxW'(pv2hp_pkg::SigLen))
        begin
            if (data_byte != pv2hp_pkg::magic_byte(byte_index_reg[3:0]))
                err = pv2hp_pkg::ST_SIG;
        end
        else if (byte_index_reg == pv2hp_pkg::POS_VER_CMD)
        begin
            if (data_byte[7:4] != pv2hp_pkg::VERSION_2)
                err = pv2hp_pkg::ST_VER;
            else if (data_byte[3:0] != pv2hp_pkg::CMD_PROXY)
                err = pv2hp_pkg::ST_CMD;
        end
        else if (byte_index_reg == pv2hp_pkg::POS_FAMILY)
        begin
            if (data_byte != pv2hp_pkg::FAM_TCP4 && data_byte != pv2hp_pkg::FAM_UDP4)
                err = pv2hp_pkg::ST_FAM;
        end
        else if (byte_index_reg == pv2hp_pkg::POS_LEN_HI)
        begin
            addr_len_next = {data_byte, addr_len_reg[7:0]};
        end
        else if (byte_index_reg == pv2hp_pkg::POS_LEN_LO)
        begin
            addr_len_next = {addr_len_reg[15:8], data_byte};
        end
        else if (byte_index_reg >= pv2hp_pkg::POS_SRC_LO &&
                 byte_index_reg <= pv2hp_pkg::POS_SRC_HI)
        begin
            src_addr_next = {src_addr_reg[23:0], data_byte};
        end
        else if (byte_index_reg == pv2hp_pkg::POS_PORT_HI ||
                 byte_index_reg == pv2hp_pkg::POS_PORT_LO)
        begin
            src_port_next = {src_port_reg[7:0], data_byte};
        end
        else
        begin
            // Drop destination fields and trailing bytes.
            err = pv2hp_pkg::ST_OK;
        end
    end

    // Keep only the first fault.
    assign first_error_next = (first_error_reg == pv2hp_pkg::ST_OK) ? err : first_error_reg;

    // Saturate the counter.
    assign byte_index_next = (byte_index_reg != pv2hp_pkg::IDX_MAX) ?
                             byte_index_reg + pv2hp_pkg::IdxW'(1) : byte_index_reg;
    assign pkt_len = byte_index_next;
    assign room    = pkt_len - pv2hp_pkg::FIXED_HDR;

    always_comb
    begin
        priority if (pkt_len < pv2hp_pkg::FIXED_HDR)
            verdict = pv2hp_pkg::ST_SHORT;
        else if (first_error_next != pv2hp_pkg::ST_OK)
            verdict = first_error_next;
        else if (addr_len_next < pv2hp_pkg::INET_BLOCK)
            verdict = pv2hp_pkg::ST_SMALL;
        else if (pv2hp_pkg::IdxW'(addr_len_next) > room)
            verdict = pv2hp_pkg::ST_OVER;
        else
            verdict = pv2hp_pkg::ST_OK;
    end

    always_comb
    begin
        result.status = verdict;
        if (verdict == pv2hp_pkg::ST_OK)
        begin
            result.client_address = src_addr_next;
            result.client_port    = src_port_next;
            result.header_length  = pv2hp_pkg::FIXED_HDR + pv2hp_pkg::IdxW'(addr_len_next);
        end
        else
        begin
            result.client_address = '0;
            result.client_port    = '0;
            result.header_length  = '0;
        end
    end

    // Advance on each request; clear everything after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            first_error_reg <= pv2hp_pkg::ST_OK;
            addr_len_reg    <= '0;
            src_addr_reg    <= '0;
            src_port_reg    <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.last)
            begin
                byte_index_reg  <= '0;
                first_error_reg <= pv2hp_pkg::ST_OK;
                addr_len_reg    <= '0;
                src_addr_reg    <= '0;
                src_port_reg    <= '0;
            end
            else
            begin
                byte_index_reg  <= byte_index_next;
                first_error_reg <= first_error_next;
                addr_len_reg    <= addr_len_next;
                src_addr_reg    <= src_addr_next;
                src_port_reg    <= src_port_next;
            end
        end
    end

endmodule

@@ rtl/core/proxy_v2_header_parser.sv @@
// Flow: a request byte is registered in the input register, then parsed; the result of the
// last byte is registered in the result register and stays until taken.
// Throughput: one byte per cycle; the input register and the result register part the
// two sides, so a waiting result stalls input only when the next last byte reaches parse.
// Reset: rst_n clears the counter, the captured fields and all valid flags at once.
`include "assert_macros.svh"

module proxy_v2_header_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] client_address,
    output logic [15:0] client_port,
    output logic [16:0] header_length
);

    logic                     s1_valid_reg, s1_valid_next;
    logic [7:0]               s1_byte_reg;
    logic                     s1_last_reg;
    logic                     out_valid_reg, out_valid_next;
    pv2hp_pkg::pv2hp_result_t out_res_reg;

    logic                     in_take;
    logic                     advance;
    pv2hp_pkg::pv2hp_ctl_t    ctl;
    pv2hp_pkg::pv2hp_result_t result;

    // A last byte may parse only when the result register is free or being emptied.
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = (advance && s1_last_reg) || (out_valid_reg && out_stall);

    assign ctl.step = advance;
    assign ctl.last = s1_last_reg;

    pv2hp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .data_byte (s1_byte_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (advance && s1_last_reg)
            out_res_reg <= result;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign client_address = out_res_reg.client_address;
    assign client_port    = out_res_reg.client_port;
    assign header_length  = out_res_reg.header_length;

    `ASSERT_IMPLY(a_stall_needs_byte, in_stall, s1_valid_reg && s1_last_reg && out_valid_reg, "input stalled without a pending last byte")
    `ASSERT_NEXT(a_last_gives_result, advance && s1_last_reg, out_valid_reg, "last byte parsed but no result held")
    `ASSERT_IMPLY(a_error_zero_fields, out_valid_reg && out_res_reg.status != pv2hp_pkg::ST_OK, client_address == '0 && client_port == '0 && header_length == '0, "error result carries nonzero fields")
    `ASSERT_IMPLY(a_ok_min_length, out_valid_reg && out_res_reg.status == pv2hp_pkg::ST_OK, header_length >= 17'd28, "ok result with header shorter than IPv4 block")

endmodule
